[design/assert_macros.svh]
// Assertion macros used by the checker module of this project.
// Holds nothing but macro definitions; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define SSC_ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssc check failed");

// Property checked at every clock edge, during reset as well.
`define SSC_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ssc check failed");

`endif

[design/ssc_pkg.sv]
// Package for the supersampled span coverage block: item type, op codes
// and fixed field widths. Depends on nothing.
`timescale 1ns / 1ps

package ssc_pkg;

  // Fixed field widths of the item and result ports.
  localparam int SLOT_W  = 3;
  localparam int SPAN_W  = 16;
  localparam int PIXEL_W = 13;
  localparam int ALPHA_W = 7;

  // Full coverage in units of 1/64.
  localparam logic [ALPHA_W-1:0] FULL_ALPHA = 7'd64;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } ssc_op_t;

  // One classified item as it travels from front to back.
  typedef struct packed {
    ssc_op_t             op;
    logic [SLOT_W-1:0]   row_slot;
    logic [SPAN_W-1:0]   span_start;
    logic [SPAN_W-1:0]   span_end;
    logic                span_present;
    logic [PIXEL_W-1:0]  pixel_x;
    logic [ALPHA_W-1:0]  prior_alpha;
  } ssc_item_t;

endpackage

[design/supersampled_span_coverage_top.sv]
// Channel  | handshake                | payload
// item     | item_valid / item_stall  | op row_slot span_start span_end span_present
//          |                          | pixel_x prior_alpha
// alpha    | alpha_valid / alpha_stall| alpha
//
// One item is taken per clock while item_stall is low. With no stalls, a pixel item passes
// through the front register, the queue, the overlap lanes, the sum, and scale and max, in
// that order, before its alpha_valid rises. Loads give no result.
// Reset clears all valid bits and all subrows.
// A stall on the result side fills the back pipeline and then the queue
// before item_stall rises; the front keeps accepting until then.
//
// Top level: ties front, queue and back together. Uses ssc_pkg.
`timescale 1ns / 1ps

module supersampled_span_coverage_top #(
  parameter int SUBSAMPLE_FACTOR = 8,
  parameter int COORD_BITS       = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         op,
  input  logic [ssc_pkg::SLOT_W-1:0]   row_slot,
  input  logic [ssc_pkg::SPAN_W-1:0]   span_start,
  input  logic [ssc_pkg::SPAN_W-1:0]   span_end,
  input  logic                         span_present,
  input  logic [ssc_pkg::PIXEL_W-1:0]  pixel_x,
  input  logic [ssc_pkg::ALPHA_W-1:0]  prior_alpha,
  output logic                         alpha_valid,
  input  logic                         alpha_stall,
  output logic [ssc_pkg::ALPHA_W-1:0]  alpha
);

  logic               push;
  ssc_pkg::ssc_item_t push_item;
  logic               queue_ready;
  logic               queue_valid;
  ssc_pkg::ssc_item_t queue_head;
  logic               pop;

  ssc_front #(
    .SUBSAMPLE_FACTOR(SUBSAMPLE_FACTOR)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .row_slot     (row_slot),
    .span_start   (span_start),
    .span_end     (span_end),
    .span_present (span_present),
    .pixel_x      (pixel_x),
    .prior_alpha  (prior_alpha),
    .push         (push),
    .push_item    (push_item),
    .queue_ready  (queue_ready)
  );

  ssc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (queue_ready),
    .valid     (queue_valid),
    .head      (queue_head),
    .pop       (pop)
  );

  ssc_back #(
    .SUBSAMPLE_FACTOR(SUBSAMPLE_FACTOR),
    .COORD_BITS      (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_valid (queue_valid),
    .queue_head  (queue_head),
    .pop         (pop),
    .alpha_valid (alpha_valid),
    .alpha_stall (alpha_stall),
    .alpha       (alpha)
  );

endmodule

[design/ssc_front.sv]
// Front stage: accepts items, drops loads to nonexistent subrows, clamps
// the prior value and hands the item to the queue. Uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_front #(
  parameter int SUBSAMPLE_FACTOR = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         op,
  input  logic [ssc_pkg::SLOT_W-1:0]   row_slot,
  input  logic [ssc_pkg::SPAN_W-1:0]   span_start,
  input  logic [ssc_pkg::SPAN_W-1:0]   span_end,
  input  logic                         span_present,
  input  logic [ssc_pkg::PIXEL_W-1:0]  pixel_x,
  input  logic [ssc_pkg::ALPHA_W-1:0]  prior_alpha,
  output logic                         push,
  output ssc_pkg::ssc_item_t           push_item,
  input  logic                         queue_ready
);

  logic               held_valid;
  logic               held_valid_next;
  ssc_pkg::ssc_item_t held_item;
  ssc_pkg::ssc_item_t cls_item;
  logic               keep;
  logic               take;

  // The held item leaves whenever the queue has room.
  assign push       = held_valid;
  assign push_item  = held_item;
  assign item_stall = held_valid && !queue_ready;
  assign take       = item_valid && !item_stall;

  // Classify the incoming item.
  always_comb begin
    cls_item              = '0;
    cls_item.op           = ssc_pkg::ssc_op_t'(op);
    cls_item.row_slot     = row_slot;
    cls_item.span_start   = span_start;
    cls_item.span_end     = span_end;
    cls_item.span_present = span_present;
    cls_item.pixel_x      = pixel_x;
    if (prior_alpha > ssc_pkg::FULL_ALPHA) begin
      cls_item.prior_alpha = ssc_pkg::FULL_ALPHA;
    end else begin
      cls_item.prior_alpha = prior_alpha;
    end
    // A load to a subrow that does not exist has no effect at all.
    keep = (cls_item.op == ssc_pkg::OP_PIXEL) ||
           (32'(row_slot) < 32'(SUBSAMPLE_FACTOR));
  end

  always_comb begin
    if (take && keep) begin
      held_valid_next = 1'b1;
    end else begin
      held_valid_next = held_valid && !queue_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  // Payload is captured on every transfer in.
  always_ff @(posedge clk) begin
    if (take) begin
      held_item <= cls_item;
    end
  end

endmodule

[design/ssc_queue.sv]
// Short FIFO between front and back so that each side can stall alone.
// Uses ssc_pkg for the item type and depth.
`timescale 1ns / 1ps

module ssc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ssc_pkg::ssc_item_t push_item,
  output logic               ready,
  output logic               valid,
  output ssc_pkg::ssc_item_t head,
  input  logic               pop
);

  localparam int PTR_W = $clog2(ssc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ssc_pkg::QUEUE_DEPTH + 1);

  ssc_pkg::ssc_item_t entries [ssc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign ready   = count < CNT_W'(ssc_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[design/ssc_back.sv]
// Back end: holds the subrow spans, applies loads in order, and runs the
// coverage pipeline (overlap lanes, sum, scale and max). Uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_back #(
  parameter int SUBSAMPLE_FACTOR = 8,
  parameter int COORD_BITS       = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         queue_valid,
  input  ssc_pkg::ssc_item_t           queue_head,
  output logic                         pop,
  output logic                         alpha_valid,
  input  logic                         alpha_stall,
  output logic [ssc_pkg::ALPHA_W-1:0]  alpha
);

  // Stored span ends keep the low COORD_BITS of the 16-bit input.
  localparam int STORE_W = (COORD_BITS < ssc_pkg::SPAN_W) ? COORD_BITS : ssc_pkg::SPAN_W;
  // Pixel window ends reach 8192 * SUBSAMPLE_FACTOR.
  localparam int WIN_W   = ssc_pkg::PIXEL_W + $clog2(SUBSAMPLE_FACTOR) + 1;
  localparam int CMP_W   = (STORE_W > WIN_W) ? STORE_W : WIN_W;
  localparam int OV_W    = $clog2(SUBSAMPLE_FACTOR + 1);
  localparam int SQ      = SUBSAMPLE_FACTOR * SUBSAMPLE_FACTOR;
  localparam int SUM_W   = $clog2(SQ + 1);
  // Scaled numerator is sum * 64; divide by SQ through a reciprocal.
  localparam int NUM_W   = SUM_W + 6;
  localparam int SHIFT   = NUM_W + $clog2(SQ);
  localparam int RECIP   = ((1 << SHIFT) + SQ - 1) / SQ;
  localparam int RCP_W   = $clog2(RECIP + 1);
  localparam int PROD_W  = NUM_W + RCP_W;

  // Span storage, one row per subrow.
  logic [STORE_W-1:0] left_ends  [SUBSAMPLE_FACTOR];
  logic [STORE_W-1:0] right_ends [SUBSAMPLE_FACTOR];
  logic [SUBSAMPLE_FACTOR-1:0] row_valid;

  // Pipeline registers.
  logic                        s1_valid;
  logic [OV_W-1:0]             s1_ov [SUBSAMPLE_FACTOR];
  logic [ssc_pkg::ALPHA_W-1:0] s1_prior;
  logic                        s2_valid;
  logic [SUM_W-1:0]            s2_sum;
  logic [ssc_pkg::ALPHA_W-1:0] s2_prior;

  // Combinational signals.
  logic                        out_en;
  logic                        s2_en;
  logic                        s1_en;
  logic                        is_load;
  logic                        is_pixel;
  logic [WIN_W-1:0]            win_lo;
  logic [WIN_W-1:0]            win_hi;
  logic [OV_W-1:0]             ov [SUBSAMPLE_FACTOR];
  logic [SUM_W-1:0]            sum;
  logic [PROD_W-1:0]           prod;
  logic [PROD_W-1:0]           cov_wide;
  logic [ssc_pkg::ALPHA_W-1:0] cov;
  logic [ssc_pkg::ALPHA_W-1:0] alpha_next;

  // Each stage advances when it is empty or its successor advances.
  assign out_en   = !alpha_valid || !alpha_stall;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign pop      = queue_valid && s1_en;
  assign is_load  = pop && (queue_head.op == ssc_pkg::OP_LOAD);
  assign is_pixel = pop && (queue_head.op == ssc_pkg::OP_PIXEL);

  // Overlap of each stored span with the pixel's subsample columns.
  always_comb begin
    logic [CMP_W-1:0] l;
    logic [CMP_W-1:0] r;
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
    win_lo = WIN_W'(queue_head.pixel_x) * WIN_W'(SUBSAMPLE_FACTOR);
    win_hi = win_lo + WIN_W'(SUBSAMPLE_FACTOR);
    lo     = CMP_W'(win_lo);
    hi     = CMP_W'(win_hi);
    for (int k = 0; k < SUBSAMPLE_FACTOR; k++) begin
      l = CMP_W'(left_ends[k]);
      r = CMP_W'(right_ends[k]);
      a = (l > lo) ? l : lo;
      b = (r < hi) ? r : hi;
      if (row_valid[k] && (l <= r) && (b > a)) begin
        ov[k] = OV_W'(b - a);
      end else begin
        ov[k] = '0;
      end
    end
  end

  // Sum of the lane overlaps.
  always_comb begin
    sum = '0;
    for (int k = 0; k < SUBSAMPLE_FACTOR; k++) begin
      sum = sum + SUM_W'(s1_ov[k]);
    end
  end

  // Scale to 1/64 units, saturate, and take the larger of prior and coverage.
  always_comb begin
    prod     = PROD_W'({s2_sum, 6'b000000}) * PROD_W'(RECIP);
    cov_wide = prod >> SHIFT;
    if (cov_wide > PROD_W'(ssc_pkg::FULL_ALPHA)) begin
      cov = ssc_pkg::FULL_ALPHA;
    end else begin
      cov = cov_wide[ssc_pkg::ALPHA_W-1:0];
    end
    alpha_next = (cov > s2_prior) ? cov : s2_prior;
  end

  // Span loads take effect in queue order.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else begin
      for (int k = 0; k < SUBSAMPLE_FACTOR; k++) begin
        if (is_load && (32'(queue_head.row_slot) == k)) begin
          row_valid[k] <= queue_head.span_present;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SUBSAMPLE_FACTOR; k++) begin
      if (is_load && (32'(queue_head.row_slot) == k)) begin
        left_ends[k]  <= queue_head.span_start[STORE_W-1:0];
        right_ends[k] <= queue_head.span_end[STORE_W-1:0];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      alpha_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= is_pixel;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        alpha_valid <= s2_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_ov    <= ov;
      s1_prior <= queue_head.prior_alpha;
    end
    if (s2_en) begin
      s2_sum   <= sum;
      s2_prior <= s1_prior;
    end
    if (out_en) begin
      alpha <= alpha_next;
    end
  end

endmodule

[design/ssc_checker.sv]
// Port-level checks for the coverage block, attached by bind.
// Uses assert_macros.svh and ssc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_stall,
  input logic                        alpha_valid,
  input logic                        alpha_stall,
  input logic [ssc_pkg::ALPHA_W-1:0] alpha
);

  // A result never shows more than full coverage.
  `SSC_ASSERT_RUN(a_alpha_range, clk, rst, alpha_valid |-> (alpha <= ssc_pkg::FULL_ALPHA))

  // Nothing comes out in the cycle after reset.
  `SSC_ASSERT_ALL(a_reset_empty, clk, $past(rst) |-> !alpha_valid)

  // A stalled result stays and holds its value.
  `SSC_ASSERT_RUN(a_alpha_hold, clk, rst, (alpha_valid && alpha_stall) |=> (alpha_valid && $stable(alpha)))

  // The input side never stalls right after reset, when every buffer is empty.
  `SSC_ASSERT_RUN(a_no_stall_after_reset, clk, rst, $fell(rst) |-> !item_stall)

endmodule

bind supersampled_span_coverage_top ssc_checker u_ssc_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .alpha_valid (alpha_valid),
  .alpha_stall (alpha_stall),
  .alpha       (alpha)
);
